@@ hw/rtl/bfc_pkg.sv @@
// Package for the box frustum cull test: item layout, command type and defaults.
// Used by bfc_front, bfc_queue, bfc_back and the top level box_frustum_cull_test.
package bfc_pkg;

    // Default configuration
    localparam int NUM_PLANES_DEF  = 6;
    localparam int COORD_WIDTH_DEF = 32;
    localparam int QUEUE_DEPTH     = 2;

    // Field widths of one input item
    localparam int IDX_W  = 3;
    localparam int VAL_W  = 32;
    localparam int HALF_W = 31;

    // Bit offsets inside s_tdata
    localparam int OFS_IDX  = 0;
    localparam int OFS_NX   = OFS_IDX + IDX_W;
    localparam int OFS_NY   = OFS_NX + VAL_W;
    localparam int OFS_NZ   = OFS_NY + VAL_W;
    localparam int OFS_OFF  = OFS_NZ + VAL_W;
    localparam int OFS_CX   = OFS_OFF + VAL_W;
    localparam int OFS_CY   = OFS_CX + VAL_W;
    localparam int OFS_CZ   = OFS_CY + VAL_W;
    localparam int OFS_HX   = OFS_CZ + VAL_W;
    localparam int OFS_HY   = OFS_HX + HALF_W;
    localparam int OFS_HZ   = OFS_HY + HALF_W;
    localparam int IN_BITS  = OFS_HZ + HALF_W;
    localparam int IN_DATA_W = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_DATA_W = 8;

    // Item kinds (tuser)
    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_BOX  = 1'b1;

    // Product and sum widths of the plane evaluation
    localparam int OPND_W = VAL_W + 1;          // center +/- half
    localparam int PROD_W = VAL_W + OPND_W;     // normal * operand
    localparam int SUM_W  = PROD_W + 3;         // three products plus offset

    // Classified command passed from front to back.
    // Load: x/y/z = normal, w = offset. Box: x/y/z = center, hx/hy/hz = half extents.
    typedef struct packed {
        logic                     kind;
        logic [IDX_W-1:0]         idx;
        logic signed [VAL_W-1:0]  x;
        logic signed [VAL_W-1:0]  y;
        logic signed [VAL_W-1:0]  z;
        logic signed [VAL_W-1:0]  w;
        logic [HALF_W-1:0]        hx;
        logic [HALF_W-1:0]        hy;
        logic [HALF_W-1:0]        hz;
    } cmd_t;

endpackage

@@ hw/rtl/bfc_front.sv @@
// Front end: accepts input items, unpacks and sign-extends fields, drops bad loads.
// Depends on bfc_pkg; feeds bfc_queue.
module bfc_front
    import bfc_pkg::*;
#(
    parameter int NUM_PLANES  = NUM_PLANES_DEF,
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [IN_DATA_W-1:0] s_tdata,
    input  logic [0:0]           s_tuser,
    input  logic                 q_ready,
    output logic                 q_push,
    output cmd_t                 q_cmd
);

    logic signed [COORD_WIDTH-1:0] nx_t, ny_t, nz_t, off_t, cx_t, cy_t, cz_t;
    logic [COORD_WIDTH-2:0]        hx_t, hy_t, hz_t;
    logic [IDX_W-1:0]              idx;
    logic                          is_box;
    logic                          bad_idx;

    // Field extraction, low COORD_WIDTH bits only (COORD_WIDTH-1 for half extents)
    assign idx    = s_tdata[OFS_IDX +: IDX_W];
    assign is_box = (s_tuser[0] == KIND_BOX);
    assign nx_t   = s_tdata[OFS_NX  +: COORD_WIDTH];
    assign ny_t   = s_tdata[OFS_NY  +: COORD_WIDTH];
    assign nz_t   = s_tdata[OFS_NZ  +: COORD_WIDTH];
    assign off_t  = s_tdata[OFS_OFF +: COORD_WIDTH];
    assign cx_t   = s_tdata[OFS_CX  +: COORD_WIDTH];
    assign cy_t   = s_tdata[OFS_CY  +: COORD_WIDTH];
    assign cz_t   = s_tdata[OFS_CZ  +: COORD_WIDTH];
    assign hx_t   = s_tdata[OFS_HX  +: COORD_WIDTH-1];
    assign hy_t   = s_tdata[OFS_HY  +: COORD_WIDTH-1];
    assign hz_t   = s_tdata[OFS_HZ  +: COORD_WIDTH-1];

    // A load to a plane beyond the store is swallowed
    assign bad_idx = ({1'b0, idx} >= (IDX_W+1)'(NUM_PLANES));

    always_comb begin
        q_cmd.kind = is_box ? KIND_BOX : KIND_LOAD;
        q_cmd.idx  = idx;
        q_cmd.x    = is_box ? VAL_W'(cx_t) : VAL_W'(nx_t);
        q_cmd.y    = is_box ? VAL_W'(cy_t) : VAL_W'(ny_t);
        q_cmd.z    = is_box ? VAL_W'(cz_t) : VAL_W'(nz_t);
        q_cmd.w    = VAL_W'(off_t);
        q_cmd.hx   = HALF_W'(hx_t);
        q_cmd.hy   = HALF_W'(hy_t);
        q_cmd.hz   = HALF_W'(hz_t);
    end

    assign s_tready = q_ready;
    assign q_push   = s_tvalid && q_ready && (is_box || !bad_idx);

endmodule

@@ hw/rtl/bfc_queue.sv @@
// Short command queue between front and back ends.
// Depends on bfc_pkg for cmd_t.
module bfc_queue
    import bfc_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  cmd_t push_cmd,
    output logic ready,
    input  logic pop,
    output logic valid,
    output cmd_t head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    cmd_t             entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign ready = (count_reg != CNT_W'(DEPTH));
    assign valid = (count_reg != '0);
    assign head  = entry_reg[rd_ptr_reg];

    // Pointer and fill count update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH-1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH-1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

@@ hw/rtl/bfc_back.sv @@
// Back end: plane store, plane sequencer, shared three-multiplier dot unit and
// the result register. Depends on bfc_pkg; takes commands from bfc_queue.
module bfc_back
    import bfc_pkg::*;
#(
    parameter int NUM_PLANES = NUM_PLANES_DEF
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic q_valid,
    input  cmd_t q_cmd,
    output logic q_pop,
    output logic m_tvalid,
    input  logic m_tready,
    output logic m_visible
);

    localparam int PW = (NUM_PLANES > 1) ? $clog2(NUM_PLANES) : 1;
    localparam logic [PW-1:0] LAST_PLANE = PW'(NUM_PLANES - 1);

    typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_WAIT, ST_HOLD} state_t;

    state_t  state_reg, state_next;
    logic [PW-1:0] cnt_reg, cnt_next;
    logic    acc_reg, acc_next;
    logic    mv_reg, mv_next;
    logic    mvis_reg, mvis_next;
    logic    s1v_reg, s1v_next, s1l_reg, s1l_next;
    logic    s2v_reg, s2v_next, s2l_reg, s2l_next;
    logic    ld_we;

    // Plane store
    logic signed [VAL_W-1:0] st_nx_reg [NUM_PLANES];
    logic signed [VAL_W-1:0] st_ny_reg [NUM_PLANES];
    logic signed [VAL_W-1:0] st_nz_reg [NUM_PLANES];
    logic signed [VAL_W-1:0] st_off_reg [NUM_PLANES];

    // Box operands: center plus and minus half extent per axis
    logic signed [OPND_W-1:0] bpx_reg, bmx_reg, bpy_reg, bmy_reg, bpz_reg, bmz_reg;

    // Pipeline data
    logic signed [VAL_W-1:0]  nx, ny, nz;
    logic signed [OPND_W-1:0] opx, opy, opz;
    logic signed [PROD_W-1:0] p1x_reg, p1y_reg, p1z_reg;
    logic signed [VAL_W-1:0]  p1d_reg;
    logic signed [SUM_W-1:0]  sum_reg;
    logic                     plane_pos;

    assign m_tvalid  = mv_reg;
    assign m_visible = mvis_reg;

    // Sequencer: pops commands, issues one plane per cycle, collects the verdict
    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        acc_next   = acc_reg;
        mv_next    = mv_reg;
        mvis_next  = mvis_reg;
        s1v_next   = 1'b0;
        s1l_next   = 1'b0;
        s2v_next   = s1v_reg;
        s2l_next   = s1l_reg;
        q_pop      = 1'b0;
        ld_we      = 1'b0;
        if (mv_reg && m_tready) begin
            mv_next = 1'b0;
        end
        if (s2v_reg) begin
            acc_next = acc_reg & plane_pos;
        end
        unique case (state_reg)
            ST_IDLE: begin
                if (q_valid) begin
                    q_pop = 1'b1;
                    if (q_cmd.kind == KIND_BOX) begin
                        cnt_next   = '0;
                        acc_next   = 1'b1;
                        state_next = ST_RUN;
                    end else begin
                        ld_we = 1'b1;
                    end
                end
            end
            ST_RUN: begin
                s1v_next = 1'b1;
                s1l_next = (cnt_reg == LAST_PLANE);
                if (cnt_reg == LAST_PLANE) begin
                    cnt_next   = '0;
                    state_next = ST_WAIT;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_WAIT: begin
                if (s2v_reg && s2l_reg) begin
                    if (!mv_reg || m_tready) begin
                        mv_next    = 1'b1;
                        mvis_next  = acc_reg & plane_pos;
                        state_next = ST_IDLE;
                    end else begin
                        state_next = ST_HOLD;
                    end
                end
            end
            ST_HOLD: begin
                if (!mv_reg || m_tready) begin
                    mv_next    = 1'b1;
                    mvis_next  = acc_reg;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            acc_reg   <= 1'b0;
            mv_reg    <= 1'b0;
            mvis_reg  <= 1'b0;
            s1v_reg   <= 1'b0;
            s1l_reg   <= 1'b0;
            s2v_reg   <= 1'b0;
            s2l_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            acc_reg   <= acc_next;
            mv_reg    <= mv_next;
            mvis_reg  <= mvis_next;
            s1v_reg   <= s1v_next;
            s1l_reg   <= s1l_next;
            s2v_reg   <= s2v_next;
            s2l_reg   <= s2l_next;
        end
    end

    // Plane store write; cleared at reset so every box is culled until loaded
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_PLANES; i++) begin
                st_nx_reg[i]  <= '0;
                st_ny_reg[i]  <= '0;
                st_nz_reg[i]  <= '0;
                st_off_reg[i] <= '0;
            end
        end else if (ld_we) begin
            st_nx_reg[q_cmd.idx[PW-1:0]]  <= q_cmd.x;
            st_ny_reg[q_cmd.idx[PW-1:0]]  <= q_cmd.y;
            st_nz_reg[q_cmd.idx[PW-1:0]]  <= q_cmd.z;
            st_off_reg[q_cmd.idx[PW-1:0]] <= q_cmd.w;
        end
    end

    // Latch box corners' extreme coordinates per axis
    always_ff @(posedge aclk) begin
        if (q_pop && (q_cmd.kind == KIND_BOX)) begin
            bpx_reg <= OPND_W'(q_cmd.x) + OPND_W'(signed'({1'b0, q_cmd.hx}));
            bmx_reg <= OPND_W'(q_cmd.x) - OPND_W'(signed'({1'b0, q_cmd.hx}));
            bpy_reg <= OPND_W'(q_cmd.y) + OPND_W'(signed'({1'b0, q_cmd.hy}));
            bmy_reg <= OPND_W'(q_cmd.y) - OPND_W'(signed'({1'b0, q_cmd.hy}));
            bpz_reg <= OPND_W'(q_cmd.z) + OPND_W'(signed'({1'b0, q_cmd.hz}));
            bmz_reg <= OPND_W'(q_cmd.z) - OPND_W'(signed'({1'b0, q_cmd.hz}));
        end
    end

    // Stage 1: pick the corner that maximizes each term, then multiply.
    // n*(c + sign(n)*h) equals n*c + |n|*h.
    assign nx  = st_nx_reg[cnt_reg];
    assign ny  = st_ny_reg[cnt_reg];
    assign nz  = st_nz_reg[cnt_reg];
    assign opx = nx[VAL_W-1] ? bmx_reg : bpx_reg;
    assign opy = ny[VAL_W-1] ? bmy_reg : bpy_reg;
    assign opz = nz[VAL_W-1] ? bmz_reg : bpz_reg;

    always_ff @(posedge aclk) begin
        p1x_reg <= PROD_W'(nx) * PROD_W'(opx);
        p1y_reg <= PROD_W'(ny) * PROD_W'(opy);
        p1z_reg <= PROD_W'(nz) * PROD_W'(opz);
        p1d_reg <= st_off_reg[cnt_reg];
    end

    // Stage 2: exact sum in Q36.32, offset aligned by 16 bits
    always_ff @(posedge aclk) begin
        sum_reg <= SUM_W'(p1x_reg) + SUM_W'(p1y_reg) + SUM_W'(p1z_reg)
                 + (SUM_W'(p1d_reg) <<< 16);
    end

    // Stage 3: strictly positive on the best corner means not culled by this plane
    assign plane_pos = !sum_reg[SUM_W-1] && (sum_reg != '0);

`ifndef SYNTHESIS
    a_pop_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> state_reg == ST_IDLE)
        else $error("command popped while a box is in flight");

    a_last_in_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        (s2v_reg && s2l_reg) |-> state_reg == ST_WAIT)
        else $error("last plane result outside wait state");

    a_issue_then_flow: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RUN) |=> s1v_reg ##1 s2v_reg)
        else $error("issued plane lost in the dot pipeline");

    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(mv_reg) |-> ($past(s2v_reg && s2l_reg) || $past(state_reg == ST_HOLD)))
        else $error("result raised without a finished box");
`endif

endmodule

@@ hw/rtl/box_frustum_cull_test.sv @@
// Box frustum cull test: a load item writes one plane, a box item gets one result.
// A box goes through the queue, plane issue in ST_RUN, the product and sum registers
// and ST_WAIT to m_tvalid; no command is popped until that box's result is registered.
// Shared three-multiplier dot unit: one plane per cycle; loads are written at pop.
// Reset (aresetn low, synchronous) clears the plane store, queue and result register.
module box_frustum_cull_test
    import bfc_pkg::*;
#(
    parameter int NUM_PLANES  = NUM_PLANES_DEF,
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // plane_index, plane_nx, plane_ny, plane_nz, plane_offset, box_center_x,
    // box_center_y, box_center_z, box_half_x, box_half_y, box_half_z
    input  logic [IN_DATA_W-1:0]  s_tdata,
    // kind
    input  logic [0:0]            s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // visible, then zero fill
    output logic [OUT_DATA_W-1:0] m_tdata
);

    logic q_push, q_ready, q_pop, q_valid;
    cmd_t q_in, q_head;
    logic visible;

    bfc_front #(
        .NUM_PLANES  (NUM_PLANES),
        .COORD_WIDTH (COORD_WIDTH)
    ) u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_ready  (q_ready),
        .q_push   (q_push),
        .q_cmd    (q_in)
    );

    bfc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_cmd (q_in),
        .ready    (q_ready),
        .pop      (q_pop),
        .valid    (q_valid),
        .head     (q_head)
    );

    bfc_back #(
        .NUM_PLANES (NUM_PLANES)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_valid   (q_valid),
        .q_cmd     (q_head),
        .q_pop     (q_pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_visible (visible)
    );

    assign m_tdata = {(OUT_DATA_W-1)'(0), visible};

endmodule
